// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL files of the LIS block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- sv/lis_pkg.sv -----
// Package of the LIS block: widths, defaults and controller/datapath structs.
// Depends on nothing; used by the interfaces and all modules.
package lis_pkg;

	localparam int DATA_W    = 32;
	localparam int MAX_N_DEF = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // take an input word
		logic scan;        // walk stored entries 0 .. count-1
		logic find_mode;   // walk picks the longest run instead of extending
		logic store;       // write new entry and restart counters
		logic trace_init;  // latch answer length and chain end
		logic trace_rd;    // read entry at chain position
		logic trace_wr;    // write answer slot, step to predecessor
		logic len_out;     // load length word into output register
		logic emit_rd;     // read answer slot
		logic emit_wr;     // load element word into output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic last;
		logic scan_done;
		logic trace_done;
		logic emit_done;
		logic out_free;
	} status_t;

endpackage

// ----- sv/lis_in_if.sv -----
// Input channel of the LIS block: one sequence element per word.
// Depends on lis_pkg.
interface lis_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [lis_pkg::DATA_W-1:0]  value;
	logic                               is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink (input valid, input value, input is_last, output ready);
endinterface

// ----- sv/lis_out_if.sv -----
// Output channel of the LIS block: length word, then subsequence words.
// Depends on lis_pkg.
interface lis_out_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [lis_pkg::DATA_W-1:0]  data;
	logic                               end_of_answer;

	modport source (output valid, output kind, output data, output end_of_answer, input ready);
	modport sink (input valid, input kind, input data, input end_of_answer, output ready);
endinterface

// ----- sv/lis_ctrl.sv -----
// Controller of the LIS block: sequences load, scan, max search, trace, emit.
// Depends on lis_pkg (cmd_t, status_t).
module lis_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  lis_pkg::status_t st,
	output lis_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN     = 8'b0000_0010,
		S_FIND     = 8'b0000_0100,
		S_TRACE_RD = 8'b0000_1000,
		S_TRACE_WR = 8'b0001_0000,
		S_EMIT_LEN = 8'b0010_0000,
		S_EMIT_RD  = 8'b0100_0000,
		S_EMIT_WR  = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!st.full) begin
						state_nxt = S_SCAN;
					end else if (in_last) begin
						state_nxt = S_FIND;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					cmd.store = 1'b1;
					state_nxt = st.last ? S_FIND : S_IDLE;
				end
			end
			S_FIND: begin
				cmd.scan      = 1'b1;
				cmd.find_mode = 1'b1;
				if (st.scan_done) begin
					cmd.trace_init = 1'b1;
					state_nxt      = S_TRACE_RD;
				end
			end
			S_TRACE_RD: begin
				cmd.trace_rd = 1'b1;
				state_nxt    = S_TRACE_WR;
			end
			S_TRACE_WR: begin
				cmd.trace_wr = 1'b1;
				state_nxt    = st.trace_done ? S_EMIT_LEN : S_TRACE_RD;
			end
			S_EMIT_LEN: begin
				if (st.out_free) begin
					cmd.len_out = 1'b1;
					state_nxt   = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (st.out_free) begin
					cmd.emit_wr = 1'b1;
					state_nxt   = st.emit_done ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/lis_dp.sv -----
// Datapath of the LIS block: element/length/predecessor/answer memories,
// scan compare unit, counters and the output register. Depends on lis_pkg.
`include "assert_macros.svh"
module lis_dp #(
	parameter int MAX_N = lis_pkg::MAX_N_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lis_pkg::cmd_t                      cmd,
	output lis_pkg::status_t                   st,
	input  logic signed [lis_pkg::DATA_W-1:0]  in_value,
	input  logic                               in_last,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic                               out_kind,
	output logic signed [lis_pkg::DATA_W-1:0]  out_data,
	output logic                               out_eoa
);

	localparam int DW = lis_pkg::DATA_W;
	localparam int CW = $clog2(MAX_N + 1);
	localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	// storage
	logic [DW-1:0] elem_mem [MAX_N];
	logic [CW-1:0] blen_mem [MAX_N];
	logic [IW-1:0] pred_mem [MAX_N];
	logic [DW-1:0] ans_mem  [MAX_N];

	logic [DW-1:0] elem_rd_q;
	logic [CW-1:0] blen_rd_q;
	logic [IW-1:0] pred_rd_q;
	logic [DW-1:0] ans_rd_q;

	logic signed [DW-1:0] val_q;
	logic                 last_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        len_q;
	logic [CW-1:0]        k_q;
	logic [IW-1:0]        pre_q;
	logic                 rd_vld_s1;
	logic [CW-1:0]        rd_idx_s1;
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic signed [DW-1:0] out_data_q;
	logic                 out_eoa_q;

	logic          scan_issue;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] t_m1;
	logic          elem_lt;
	logic          take;
	logic [CW-1:0] new_len;
	logic          out_load;

	assign scan_issue = cmd.scan && (idx_q < cnt_q);
	assign rd_addr    = cmd.trace_rd ? pre_q : idx_q[IW-1:0];
	assign t_m1       = idx_q - CW'(1);

	// compare unit: extend a run (scan) or pick the longest run (find)
	assign elem_lt = $signed(elem_rd_q) < val_q;
	assign take    = rd_vld_s1 && (cmd.find_mode ? (blen_rd_q > len_q)
	                                             : (elem_lt && (blen_rd_q >= len_q)));
	assign new_len = cmd.find_mode ? blen_rd_q : blen_rd_q + CW'(1);

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			elem_mem[cnt_q[IW-1:0]] <= val_q;
			blen_mem[cnt_q[IW-1:0]] <= len_q;
			pred_mem[cnt_q[IW-1:0]] <= pre_q;
		end
		if (scan_issue || cmd.trace_rd) begin
			elem_rd_q <= elem_mem[rd_addr];
			blen_rd_q <= blen_mem[rd_addr];
			pred_rd_q <= pred_mem[rd_addr];
		end
		if (cmd.trace_wr) begin
			ans_mem[t_m1[IW-1:0]] <= elem_rd_q;
		end
		if (cmd.emit_rd) begin
			ans_rd_q <= ans_mem[idx_q[IW-1:0]];
		end
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= in_value;
		end
	end

	// counters, run length, chain position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			len_q     <= '0;
			k_q       <= '0;
			pre_q     <= '0;
			last_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= scan_issue;
			rd_idx_s1 <= idx_q;
			if (cmd.load) begin
				last_q <= in_last;
			end
			if (cmd.store) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.trace_init) begin
				cnt_q <= '0;
			end
			if (cmd.load || cmd.store) begin
				idx_q <= '0;
				len_q <= CW'(1);
				pre_q <= '0;
			end else if (cmd.trace_init) begin
				k_q   <= len_q;
				idx_q <= len_q;
			end else if (cmd.trace_wr) begin
				pre_q <= pred_rd_q;
				idx_q <= t_m1;
			end else if (cmd.len_out) begin
				idx_q <= '0;
			end else if (cmd.emit_wr) begin
				idx_q <= idx_q + CW'(1);
			end else begin
				if (scan_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (take) begin
					len_q <= new_len;
					pre_q <= rd_idx_s1[IW-1:0];
				end
			end
		end
	end

	// output register
	assign out_load = cmd.len_out || cmd.emit_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.len_out) begin
			out_kind_q <= 1'b0;
			out_data_q <= DW'(k_q);
			out_eoa_q  <= 1'b0;
		end else if (cmd.emit_wr) begin
			out_kind_q <= 1'b1;
			out_data_q <= ans_rd_q;
			out_eoa_q  <= st.emit_done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;
	assign out_eoa   = out_eoa_q;

	// status
	assign st.full       = cnt_q >= CW'(MAX_N);
	assign st.last       = last_q;
	assign st.scan_done  = (idx_q == cnt_q) && !rd_vld_s1;
	assign st.trace_done = idx_q == CW'(1);
	assign st.emit_done  = idx_q == (k_q - CW'(1));
	assign st.out_free   = !out_valid_q || out_ready;

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(MAX_N))
	`ASSERT_NEVER(a_rd_in_range, clk, arst_n, rd_vld_s1 && (rd_idx_s1 >= cnt_q))
	`ASSERT_AT(a_len_nonzero, clk, arst_n, cmd.len_out |-> (k_q != '0))
	`ASSERT_AT(a_load_free, clk, arst_n, out_load |-> st.out_free)

endmodule

// ----- sv/longest_increasing_subsequence.sv -----
// Top level of the LIS block: controller plus datapath behind two channels.
// Depends on lis_pkg, lis_in_if, lis_out_if, lis_ctrl, lis_dp.
//
//   channel  dir  word                          handshake
//   item     in   value, is_last                valid/ready
//   result   out  kind, data, end_of_answer     valid/ready
//
// An element is accepted, then every stored element is read in turn on the single
// memory read port, and the new entry is written once the last read returns. The
// marked last element is followed by a max search, a traceback of the answer and
// output of the length and answer words, which can stall on output back-pressure.
// Reset clears the count and the controller; the memories need no clearing.
// Input waits while an answer is built or emitted; the last word may sit in
// the output register while the next sequence loads.
module longest_increasing_subsequence #(
	parameter int MAX_N = lis_pkg::MAX_N_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lis_in_if.sink    item,
	lis_out_if.source result
);

	lis_pkg::cmd_t    cmd;
	lis_pkg::status_t st;

	lis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_last  (item.is_last),
		.in_ready (item.ready),
		.st       (st),
		.cmd      (cmd)
	);

	lis_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_value  (item.value),
		.in_last   (item.is_last),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_kind  (result.kind),
		.out_data  (result.data),
		.out_eoa   (result.end_of_answer)
	);

endmodule
